// File: hdl/arrowhead_corner_points_core_macros.svh
// ---------------------------------------------------------------------------
// Arrowhead corner points: assertion macros
// Concurrent check wrappers; they expand to nothing in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ARROWHEAD_CORNER_POINTS_CORE_MACROS_SVH
`define ARROWHEAD_CORNER_POINTS_CORE_MACROS_SVH
`ifndef SYNTHESIS
// check while out of reset
`define ACP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// check at every edge, reset included
`define ACP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ACP_ASSERT(lbl, prop, msg)
`define ACP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hdl/ahcp_pkg.sv
// ---------------------------------------------------------------------------
// Arrowhead corner points: shared package
// Widths, limits and the per-beat sideband that rides along the cell chain.
// ---------------------------------------------------------------------------
`default_nettype none

package ahcp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 16;
    localparam int HEAD_W        = 8;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int SQ_W          = 2 * DIFF_W;
    localparam int OUT_MAX       = 32767;
    localparam int OUT_MIN       = -32768;
    localparam int IN_TDATA_W    = 72;
    localparam int OUT_TDATA_W   = 96;

    typedef struct packed {
        logic en;
        logic valid;
    } t_ctl;

    typedef struct packed {
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic [HEAD_W-1:0]         head;
        logic                      degen;
        logic                      neg_x;
        logic                      neg_y;
        logic [COORD_W-1:0]        mag_x;
        logic [COORD_W-1:0]        mag_y;
    } t_side;

endpackage

`default_nettype wire

// File: hdl/ahcp_front.sv
// ---------------------------------------------------------------------------
// Arrowhead corner points: front cells
// Difference, squares and squared length over three registered stages.
// ---------------------------------------------------------------------------
`default_nettype none

module ahcp_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire ahcp_pkg::t_ctl                     i_ctl,
    input  wire logic signed [ahcp_pkg::COORD_W-1:0] i_start_x,
    input  wire logic signed [ahcp_pkg::COORD_W-1:0] i_start_y,
    input  wire logic signed [ahcp_pkg::COORD_W-1:0] i_end_x,
    input  wire logic signed [ahcp_pkg::COORD_W-1:0] i_end_y,
    input  wire logic [ahcp_pkg::HEAD_W-1:0]        i_head,
    output logic                                    o_valid,
    output ahcp_pkg::t_side                         o_side,
    output logic [ahcp_pkg::SQ_W-1:0]               o_sq
);
    import ahcp_pkg::*;

    logic                     r_v1, r_v2, r_v3;
    t_side                    r_s1, r_s2, r_s3, n_s1;
    logic signed [DIFF_W-1:0] r_dx, r_dy, n_dx, n_dy;
    logic [SQ_W-2:0]          r_dx2, r_dy2;
    logic [SQ_W-1:0]          r_sq;
    logic signed [SQ_W-1:0]   sq_x, sq_y;

    always_comb begin
        n_dx = {i_end_x[COORD_W-1], i_end_x} - {i_start_x[COORD_W-1], i_start_x};
        n_dy = {i_end_y[COORD_W-1], i_end_y} - {i_start_y[COORD_W-1], i_start_y};
        n_s1.end_x = i_end_x;
        n_s1.end_y = i_end_y;
        n_s1.head  = i_head;
        n_s1.degen = (i_start_x == i_end_x) && (i_start_y == i_end_y);
        n_s1.neg_x = n_dx[DIFF_W-1];
        n_s1.neg_y = n_dy[DIFF_W-1];
        n_s1.mag_x = n_dx[DIFF_W-1] ? COORD_W'(-n_dx) : n_dx[COORD_W-1:0];
        n_s1.mag_y = n_dy[DIFF_W-1] ? COORD_W'(-n_dy) : n_dy[COORD_W-1:0];
    end

    assign sq_x = r_dx * r_dx;
    assign sq_y = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_ctl.en) begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_s1  <= n_s1;
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_s2  <= r_s1;
            r_dx2 <= sq_x[SQ_W-2:0];
            r_dy2 <= sq_y[SQ_W-2:0];
            r_s3  <= r_s2;
            r_sq  <= {1'b0, r_dx2} + {1'b0, r_dy2};
        end
    end

    assign o_valid = r_v3;
    assign o_side  = r_s3;
    assign o_sq    = r_sq;

endmodule

`default_nettype wire

// File: hdl/ahcp_sqrt_cell.sv
// ---------------------------------------------------------------------------
// Arrowhead corner points: square root cell
// One restoring root digit per cell; IDX selects the radicand pair.
// ---------------------------------------------------------------------------
`default_nettype none

module ahcp_sqrt_cell #(
    parameter int FRAC_BITS = ahcp_pkg::FRAC_BITS_DEF,
    parameter int IDX       = 0
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire ahcp_pkg::t_ctl           i_ctl,
    input  wire ahcp_pkg::t_side          i_side,
    input  wire logic [ahcp_pkg::SQ_W-1:0] i_sq,
    input  wire logic [FRAC_BITS+18:0]    i_rem,
    input  wire logic [FRAC_BITS+16:0]    i_root,
    output logic                          o_valid,
    output ahcp_pkg::t_side               o_side,
    output logic [ahcp_pkg::SQ_W-1:0]     o_sq,
    output logic [FRAC_BITS+18:0]         o_rem,
    output logic [FRAC_BITS+16:0]         o_root
);
    import ahcp_pkg::*;

    localparam int RT_W = FRAC_BITS + 17;
    localparam int RM_W = FRAC_BITS + 19;

    logic [1:0]      pair;
    logic [RM_W-1:0] rem_sh, trial, n_rem;
    logic [RT_W-1:0] n_root;
    logic            fits;
    logic            r_valid;
    t_side           r_side;
    logic [SQ_W-1:0] r_sq;
    logic [RM_W-1:0] r_rem;
    logic [RT_W-1:0] r_root;

    generate
        if (IDX >= FRAC_BITS) begin : g_pair
            localparam int P = 2 * (IDX - FRAC_BITS);
            assign pair = i_sq[P+1:P];
        end else begin : g_zero
            assign pair = 2'b00;
        end
    endgenerate

    always_comb begin
        rem_sh = {i_rem[RM_W-3:0], pair};
        trial  = {i_root, 2'b01};
        fits   = rem_sh >= trial;
        n_rem  = fits ? rem_sh - trial : rem_sh;
        n_root = {i_root[RT_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_side <= i_side;
            r_sq   <= i_sq;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_sq    = r_sq;
    assign o_rem   = r_rem;
    assign o_root  = r_root;

endmodule

`default_nettype wire

// File: hdl/ahcp_div_cell.sv
// ---------------------------------------------------------------------------
// Arrowhead corner points: divider cell
// One restoring quotient bit per cell for both unit components.
// ---------------------------------------------------------------------------
`default_nettype none

module ahcp_div_cell #(
    parameter int FRAC_BITS = ahcp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire ahcp_pkg::t_ctl        i_ctl,
    input  wire ahcp_pkg::t_side       i_side,
    input  wire logic [FRAC_BITS+16:0] i_len,
    input  wire logic [FRAC_BITS+17:0] i_rem_x,
    input  wire logic [FRAC_BITS+17:0] i_rem_y,
    input  wire logic [FRAC_BITS:0]    i_q_x,
    input  wire logic [FRAC_BITS:0]    i_q_y,
    output logic                       o_valid,
    output ahcp_pkg::t_side            o_side,
    output logic [FRAC_BITS+16:0]      o_len,
    output logic [FRAC_BITS+17:0]      o_rem_x,
    output logic [FRAC_BITS+17:0]      o_rem_y,
    output logic [FRAC_BITS:0]         o_q_x,
    output logic [FRAC_BITS:0]         o_q_y
);
    import ahcp_pkg::*;

    localparam int RT_W = FRAC_BITS + 17;
    localparam int DR_W = FRAC_BITS + 18;

    logic [DR_W-1:0]    sh_x, sh_y, len_w, n_rem_x, n_rem_y;
    logic               ge_x, ge_y;
    logic               r_valid;
    t_side              r_side;
    logic [RT_W-1:0]    r_len;
    logic [DR_W-1:0]    r_rem_x, r_rem_y;
    logic [FRAC_BITS:0] r_q_x, r_q_y;

    always_comb begin
        len_w   = {1'b0, i_len};
        sh_x    = {i_rem_x[DR_W-2:0], 1'b0};
        sh_y    = {i_rem_y[DR_W-2:0], 1'b0};
        ge_x    = sh_x >= len_w;
        ge_y    = sh_y >= len_w;
        n_rem_x = ge_x ? sh_x - len_w : sh_x;
        n_rem_y = ge_y ? sh_y - len_w : sh_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_side  <= i_side;
            r_len   <= i_len;
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_q_x   <= {i_q_x[FRAC_BITS-1:0], ge_x};
            r_q_y   <= {i_q_y[FRAC_BITS-1:0], ge_y};
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_len   = r_len;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_q_x   = r_q_x;
    assign o_q_y   = r_q_y;

endmodule

`default_nettype wire

// File: hdl/ahcp_back.sv
// ---------------------------------------------------------------------------
// Arrowhead corner points: back cells
// Scale by head length, side offset by a third, corner sums, round and clamp.
// ---------------------------------------------------------------------------
`default_nettype none

module ahcp_back #(
    parameter int FRAC_BITS = ahcp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ahcp_pkg::t_ctl                 i_ctl,
    input  wire ahcp_pkg::t_side                i_side,
    input  wire logic [FRAC_BITS:0]             i_q_x,
    input  wire logic [FRAC_BITS:0]             i_q_y,
    output logic                                o_valid,
    output logic [ahcp_pkg::COORD_W-1:0]        o_plus_x,
    output logic [ahcp_pkg::COORD_W-1:0]        o_plus_y,
    output logic [ahcp_pkg::COORD_W-1:0]        o_minus_x,
    output logic [ahcp_pkg::COORD_W-1:0]        o_minus_y,
    output logic [ahcp_pkg::COORD_W-1:0]        o_tip_x,
    output logic [ahcp_pkg::COORD_W-1:0]        o_tip_y,
    output logic                                o_degen
);
    import ahcp_pkg::*;

    localparam int MW = FRAC_BITS + HEAD_W;
    localparam int K  = MW + 1;
    localparam logic [K-2:0] DIV3_MUL = (K-1)'(((64'd1 << K) + 64'd2) / 64'd3);
    localparam int CW = FRAC_BITS + 19;
    localparam int QW = CW - FRAC_BITS;
    localparam logic [CW-1:0] RND = {{QW{1'b0}}, {FRAC_BITS{1'b1}}};
    localparam logic signed [QW-1:0] Q_MAX = QW'(OUT_MAX);
    localparam logic signed [QW-1:0] Q_MIN = QW'(OUT_MIN);

    function automatic logic [COORD_W-1:0] to_out(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        logic signed [QW-1:0] q;
        t = v[CW-1] ? v + $signed(RND) : v;
        q = t[CW-1:FRAC_BITS];
        if (q > Q_MAX) begin
            to_out = COORD_W'(OUT_MAX);
        end else if (q < Q_MIN) begin
            to_out = COORD_W'(OUT_MIN);
        end else begin
            to_out = q[COORD_W-1:0];
        end
    endfunction

    logic                 r_v1, r_v2, r_v3, r_v4, r_v5;
    t_side                r_s1, r_s2, r_s3, r_s4;
    logic [MW:0]          prod_x, prod_y;
    logic [MW-1:0]        r_max, r_may, r_max2, r_may2;
    logic [MW+K-2:0]      third_x, third_y;
    logic [MW-2:0]        r_thx, r_thy;
    logic signed [CW-1:0] ex_s, ey_s, ax_w, ay_w, thx_w, thy_w;
    logic signed [CW-1:0] r_bx, r_by, r_sx, r_sy;
    logic signed [CW-1:0] r_px, r_py, r_mx, r_my;
    logic [COORD_W-1:0]   r_opx, r_opy, r_omx, r_omy, r_tx, r_ty;
    logic                 r_dg;

    assign prod_x  = i_side.head * i_q_x;
    assign prod_y  = i_side.head * i_q_y;
    assign third_x = r_max * DIV3_MUL;
    assign third_y = r_may * DIV3_MUL;

    always_comb begin
        ex_s  = {{3{r_s2.end_x[COORD_W-1]}}, r_s2.end_x, {FRAC_BITS{1'b0}}};
        ey_s  = {{3{r_s2.end_y[COORD_W-1]}}, r_s2.end_y, {FRAC_BITS{1'b0}}};
        ax_w  = $signed(CW'(r_max2));
        ay_w  = $signed(CW'(r_may2));
        thx_w = $signed(CW'(r_thx));
        thy_w = $signed(CW'(r_thy));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_ctl.en) begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            // scale the unit vector magnitudes by the head length
            r_s1   <= i_side;
            r_max  <= prod_x[MW-1:0];
            r_may  <= prod_y[MW-1:0];
            // divide by three through the reciprocal
            r_s2   <= r_s1;
            r_max2 <= r_max;
            r_may2 <= r_may;
            r_thx  <= third_x[MW+K-2:K];
            r_thy  <= third_y[MW+K-2:K];
            // step back from the tip, apply signs
            r_s3   <= r_s2;
            r_bx   <= ex_s - (r_s2.neg_x ? -ax_w : ax_w);
            r_by   <= ey_s - (r_s2.neg_y ? -ay_w : ay_w);
            r_sx   <= r_s2.neg_y ? -thy_w : thy_w;
            r_sy   <= r_s2.neg_x ? -thx_w : thx_w;
            // base corners
            r_s4   <= r_s3;
            r_px   <= r_bx + r_sx;
            r_py   <= r_by - r_sy;
            r_mx   <= r_bx - r_sx;
            r_my   <= r_by + r_sy;
            // round toward zero, clamp, zero out a degenerate segment
            r_opx  <= r_s4.degen ? '0 : to_out(r_px);
            r_opy  <= r_s4.degen ? '0 : to_out(r_py);
            r_omx  <= r_s4.degen ? '0 : to_out(r_mx);
            r_omy  <= r_s4.degen ? '0 : to_out(r_my);
            r_tx   <= r_s4.end_x;
            r_ty   <= r_s4.end_y;
            r_dg   <= r_s4.degen;
        end
    end

    assign o_valid   = r_v5;
    assign o_plus_x  = r_opx;
    assign o_plus_y  = r_opy;
    assign o_minus_x = r_omx;
    assign o_minus_y = r_omy;
    assign o_tip_x   = r_tx;
    assign o_tip_y   = r_ty;
    assign o_degen   = r_dg;

endmodule

`default_nettype wire

// File: hdl/arrowhead_corner_points_core.sv
// ---------------------------------------------------------------------------
// Arrowhead corner points core
// Tip and two base corners of an arrowhead at the end of a line segment.
// ---------------------------------------------------------------------------
// One segment enters per clock and one result beat leaves per clock. The chain
// holds three front cells, one cell per square root digit (FRAC_BITS+17 of
// them), one cell per quotient bit of the unit vector divide (FRAC_BITS+1),
// and five back cells, the last being the output register. The whole chain
// advances together and holds while a result sits in the output register and
// the sink is not ready; in that time no new segment is taken. A zero-length
// segment sets tuser and clears both base corners; the tip always echoes the
// end point.
`default_nettype none
`include "arrowhead_corner_points_core_macros.svh"

module arrowhead_corner_points_core #(
    parameter int FRAC_BITS = ahcp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // start_x, start_y, end_x, end_y, head_length
    input  wire logic [ahcp_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // corner_plus_x, corner_plus_y, corner_minus_x, corner_minus_y, tip_x, tip_y
    output logic [ahcp_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // degenerate
    output logic [0:0]                            o_m_axis_tuser
);
    import ahcp_pkg::*;

    localparam int N_SQ = FRAC_BITS + 17;
    localparam int N_DV = FRAC_BITS + 1;
    localparam int RT_W = FRAC_BITS + 17;
    localparam int RM_W = FRAC_BITS + 19;
    localparam int DR_W = FRAC_BITS + 18;

    logic en;

    // square root chain
    logic               sq_v    [0:N_SQ];
    t_side              sq_side [0:N_SQ];
    logic [SQ_W-1:0]    sq_sq   [0:N_SQ];
    logic [RM_W-1:0]    sq_rem  [0:N_SQ];
    logic [RT_W-1:0]    sq_root [0:N_SQ];

    // divide chain
    logic               dv_v    [0:N_DV];
    t_side              dv_side [0:N_DV];
    logic [RT_W-1:0]    dv_len  [0:N_DV];
    logic [DR_W-1:0]    dv_rx   [0:N_DV];
    logic [DR_W-1:0]    dv_ry   [0:N_DV];
    logic [FRAC_BITS:0] dv_qx   [0:N_DV];
    logic [FRAC_BITS:0] dv_qy   [0:N_DV];

    logic               out_v, out_dg;
    logic [COORD_W-1:0] out_px, out_py, out_mx, out_my, out_tx, out_ty;

    // advance everything unless a finished beat is held back
    assign en              = !out_v || i_m_axis_tready;
    assign o_s_axis_tready = en;

    ahcp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     ('{en: en, valid: i_s_axis_tvalid}),
        .i_start_x ($signed(i_s_axis_tdata[15:0])),
        .i_start_y ($signed(i_s_axis_tdata[31:16])),
        .i_end_x   ($signed(i_s_axis_tdata[47:32])),
        .i_end_y   ($signed(i_s_axis_tdata[63:48])),
        .i_head    (i_s_axis_tdata[71:64]),
        .o_valid   (sq_v[0]),
        .o_side    (sq_side[0]),
        .o_sq      (sq_sq[0])
    );

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    // most significant root digit first
    generate
        for (genvar k = 0; k < N_SQ; k++) begin : g_sqrt
            ahcp_sqrt_cell #(
                .FRAC_BITS (FRAC_BITS),
                .IDX       (N_SQ - 1 - k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   ('{en: en, valid: sq_v[k]}),
                .i_side  (sq_side[k]),
                .i_sq    (sq_sq[k]),
                .i_rem   (sq_rem[k]),
                .i_root  (sq_root[k]),
                .o_valid (sq_v[k+1]),
                .o_side  (sq_side[k+1]),
                .o_sq    (sq_sq[k+1]),
                .o_rem   (sq_rem[k+1]),
                .o_root  (sq_root[k+1])
            );
        end
    endgenerate

    // quotient never exceeds one, so start from the numerator shifted up by only FRAC_BITS-1
    assign dv_v[0]    = sq_v[N_SQ];
    assign dv_side[0] = sq_side[N_SQ];
    assign dv_len[0]  = sq_root[N_SQ];
    assign dv_rx[0]   = DR_W'(sq_side[N_SQ].mag_x) << (FRAC_BITS - 1);
    assign dv_ry[0]   = DR_W'(sq_side[N_SQ].mag_y) << (FRAC_BITS - 1);
    assign dv_qx[0]   = '0;
    assign dv_qy[0]   = '0;

    generate
        for (genvar k = 0; k < N_DV; k++) begin : g_div
            ahcp_div_cell #(
                .FRAC_BITS (FRAC_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   ('{en: en, valid: dv_v[k]}),
                .i_side  (dv_side[k]),
                .i_len   (dv_len[k]),
                .i_rem_x (dv_rx[k]),
                .i_rem_y (dv_ry[k]),
                .i_q_x   (dv_qx[k]),
                .i_q_y   (dv_qy[k]),
                .o_valid (dv_v[k+1]),
                .o_side  (dv_side[k+1]),
                .o_len   (dv_len[k+1]),
                .o_rem_x (dv_rx[k+1]),
                .o_rem_y (dv_ry[k+1]),
                .o_q_x   (dv_qx[k+1]),
                .o_q_y   (dv_qy[k+1])
            );
        end
    endgenerate

    ahcp_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     ('{en: en, valid: dv_v[N_DV]}),
        .i_side    (dv_side[N_DV]),
        .i_q_x     (dv_qx[N_DV]),
        .i_q_y     (dv_qy[N_DV]),
        .o_valid   (out_v),
        .o_plus_x  (out_px),
        .o_plus_y  (out_py),
        .o_minus_x (out_mx),
        .o_minus_y (out_my),
        .o_tip_x   (out_tx),
        .o_tip_y   (out_ty),
        .o_degen   (out_dg)
    );

    assign o_m_axis_tvalid = out_v;
    assign o_m_axis_tdata  = {out_ty, out_tx, out_my, out_mx, out_py, out_px};
    assign o_m_axis_tuser  = out_dg;

    `ACP_ASSERT(a_degen_zero, (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata[63:0] == 64'd0), "degenerate beat carries nonzero corners")
    `ACP_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_m_axis_tvalid, "result valid right after reset")
    `ACP_ASSERT(a_stall_cause, !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready), "input held without a blocked result")

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// ---------------------------------------------------------------------------
// Arrowhead corner points core: testbench
// Drives segments into the stream input, predicts tip, base corners and the
// zero-length flag in fixed point, and compares each result beat in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import ahcp_pkg::*;

    localparam int FB      = FRAC_BITS_DEF;
    localparam int LATENCY = 2 * FB + 26;

    typedef struct packed {
        logic signed [15:0] sx, sy, ex, ey;
        logic [7:0]         head;
    } t_seg;

    typedef struct packed {
        logic signed [15:0] px, py, mx, my, tx, ty;
        logic               degen;
    } t_corners;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [IN_TDATA_W-1:0]  s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_data;
    logic [0:0]             m_user;

    t_corners expected_corners[$];
    int  mismatches = 0;
    bit  idle_enable = 1'b1;
    int  stall_left = 0;

    always #2 i_clk = ~i_clk;

    arrowhead_corner_points_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user)
    );

    // floor(sqrt(v) * 2^FB), digit by digit
    function automatic longint unsigned length_q(longint unsigned v);
        longint unsigned r = 0, q = 0, trial, pair;
        for (int i = 17 + FB - 1; i >= 0; i--) begin
            pair = (i >= FB) ? ((v >> (2 * (i - FB))) & 3) : 0;
            r = (r << 2) | pair;
            trial = (q << 2) | 1;
            if (r >= trial) begin
                r -= trial;
                q = (q << 1) | 1;
            end else begin
                q = q << 1;
            end
        end
        return q;
    endfunction

    function automatic longint direction_q(longint d, longint unsigned len);
        longint unsigned m;
        longint unsigned q;
        m = (d < 0) ? -d : d;
        q = (m << (2 * FB)) / len;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [15:0] clamp_pixel(longint v_q);
        longint v = v_q / (longint'(1) << FB);
        if (v < OUT_MIN) v = OUT_MIN;
        if (v > OUT_MAX) v = OUT_MAX;
        return v[15:0];
    endfunction

    function automatic t_corners arrow_corners(t_seg s);
        t_corners c;
        longint dx, dy, ux, uy, h, bx, by, sdx, sdy;
        longint unsigned len;
        dx = longint'(s.ex) - longint'(s.sx);
        dy = longint'(s.ey) - longint'(s.sy);
        h  = longint'(s.head);
        c = '0;
        c.tx = s.ex;
        c.ty = s.ey;
        if (dx == 0 && dy == 0) begin
            c.degen = 1'b1;
            return c;
        end
        len = length_q(dx * dx + dy * dy);
        ux  = direction_q(dx, len);
        uy  = direction_q(dy, len);
        sdx = (h * uy) / 3;
        sdy = (h * ux) / 3;
        bx  = (longint'(s.ex) << FB) - h * ux;
        by  = (longint'(s.ey) << FB) - h * uy;
        c.px = clamp_pixel(bx + sdx);
        c.py = clamp_pixel(by - sdy);
        c.mx = clamp_pixel(bx - sdx);
        c.my = clamp_pixel(by + sdy);
        return c;
    endfunction

    // Send one segment; sometimes drop valid for a random gap before it.
    task automatic send_segment(t_seg s);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_data  <= {s.head, s.ey, s.ex, s.sy, s.sx};
        s_valid <= 1'b1;
        do @(posedge i_clk); while (!s_ready);
        expected_corners.push_back(arrow_corners(s));
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
    endtask

    function automatic t_seg make_seg(int sx, int sy, int ex, int ey, int h);
        t_seg s;
        s.sx = 16'(sx); s.sy = 16'(sy); s.ex = 16'(ex); s.ey = 16'(ey);
        s.head = 8'(h);
        return s;
    endfunction

    // Directed: extremes, zero length, zero head, saturation.
    task automatic test_directed();
        send_segment(make_seg(0, 0, 0, 0, 10));
        send_segment(make_seg(-32768, -32768, -32768, -32768, 255));
        send_segment(make_seg(0, 0, 100, 0, 0));
        send_segment(make_seg(0, 0, 100, 0, 30));
        send_segment(make_seg(0, 0, 0, 100, 30));
        send_segment(make_seg(5, 5, 1, 2, 255));
        send_segment(make_seg(-32768, -32768, 32767, 32767, 255));
        send_segment(make_seg(32767, 32767, -32768, -32768, 255));
        send_segment(make_seg(32767, 0, -32768, 0, 255));
        send_segment(make_seg(-32768, 32767, 32767, -32768, 255));
        send_segment(make_seg(0, 0, -32768, 32767, 255));
        send_segment(make_seg(0, 0, 32767, 1, 255));
        send_segment(make_seg(1, 0, 0, 0, 255));
        send_segment(make_seg(0, 1, 0, 0, 1));
        send_segment(make_seg(-32768, 0, -32767, 0, 255));
        send_segment(make_seg(32767, -32768, 32766, 32767, 128));
        send_segment(make_seg(-1, -1, 32767, -32768, 3));
        send_segment(make_seg(100, 100, 100, 100, 0));
    endtask

    // Random: half short segments, most of the rest full range, some zero length.
    task automatic test_random(int count);
        t_seg s;
        int   k;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, 9);
            s.sx = 16'($urandom); s.sy = 16'($urandom); s.head = 8'($urandom);
            if (k < 5) begin
                s.ex = s.sx + $signed(16'($urandom_range(0, 1023) - 512));
                s.ey = s.sy + $signed(16'($urandom_range(0, 1023) - 512));
            end else if (k < 9) begin
                s.ex = 16'($urandom); s.ey = 16'($urandom);
            end else begin
                s.ex = s.sx; s.ey = s.sy;
            end
            send_segment(s);
        end
    endtask

    // Result side: random stall bursts, none in the last part.
    always @(negedge i_clk) begin
        if (!idle_enable) begin
            stall_left = 0;
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= (stall_left == 0);
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 11);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_corners got, want;
        if (i_rst_n && m_valid && m_ready) begin
            got.px = m_data[15:0];  got.py = m_data[31:16];
            got.mx = m_data[47:32]; got.my = m_data[63:48];
            got.tx = m_data[79:64]; got.ty = m_data[95:80];
            got.degen = m_user[0];
            if (expected_corners.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
            end else begin
                want = expected_corners.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("expected %p got %p", want, got);
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("arrowhead_corner_points_core: mismatch");
        $finish;
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(1100);
        idle_enable = 1'b0;
        test_random(200);
        stop_sending();
        while (expected_corners.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (mismatches == 0 && expected_corners.size() == 0) begin
            $display("arrowhead_corner_points_core: match");
        end else begin
            $display("arrowhead_corner_points_core: mismatch");
        end
        $finish;
    end
endmodule

`default_nettype wire
